/* design/ssbs_pkg.sv */
// Shared types and codes for the blocked sorted key/payload store.
package ssbs_pkg;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_SEARCH = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [30:0] key;
      logic [31:0] payload;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_payload;
      logic [3:0]  block_index;
      logic [5:0]  slot_index;
   } rsp_item_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_OPEN,
      OP_NEXT_BLK,
      OP_NEXT_SLOT,
      OP_READ,
      OP_SH_INIT,
      OP_RD_UP,
      OP_WR_UP,
      OP_INSERT,
      OP_HIT,
      OP_RD_DN,
      OP_WR_DN,
      OP_REM_DONE,
      OP_MISS,
      OP_FULL
   } dp_op_type;

   typedef struct packed {
      logic is_insert;
      logic is_search;
      logic is_clear;
      logic alloc_zero;
      logic alloc_full;
      logic blk_end;
      logic blk_last;
      logic cnt_full;
      logic slot_at_cnt;
      logic slot_last;
      logic sh_at_slot;
      logic key_lt;
      logic key_eq;
   } dp_stat_type;

   typedef struct packed {
      dp_op_type op;
      logic      clear;
   } dp_cmd_type;

endpackage

/* design/ssbs_dp.sv */
// Datapath: entry memory, block counts, counters and result register.
module ssbs_dp
   import ssbs_pkg::*;
#(
   parameter int SLOTS_PER_BLOCK = 64,
   parameter int MAX_BLOCKS      = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  dp_cmd_type   cmd,
   input  req_item_type req_data,
   output dp_stat_type  stat,
   output rsp_item_type rsp_data
);

   localparam int SW    = $clog2(SLOTS_PER_BLOCK);
   localparam int CW    = $clog2(SLOTS_PER_BLOCK + 1);
   localparam int IW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int BW    = $clog2(MAX_BLOCKS + 1);
   localparam int DEPTH = MAX_BLOCKS * SLOTS_PER_BLOCK;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef struct packed {
      logic [30:0] key;
      logic [31:0] payload;
   } entry_type;

   entry_type    mem [DEPTH];
   logic [CW-1:0] counts [MAX_BLOCKS];

   req_item_type req_ff;
   logic [BW-1:0] blk_ff, alloc_ff;
   logic [CW-1:0] slot_ff, sh_ff;
   entry_type    rd_ff;
   rsp_item_type rsp_ff;

   logic [IW-1:0] blk_ix;
   logic [CW-1:0] cnt_cur;
   logic [CW-1:0] rd_idx, wr_idx;
   logic [AW-1:0] rd_addr, wr_addr;
   entry_type    wr_data;
   logic         rd_en, wr_en;

   assign blk_ix  = blk_ff[IW-1:0];
   assign cnt_cur = counts[blk_ix];

   always_comb begin
      rd_en   = 1'b0;
      wr_en   = 1'b0;
      rd_idx  = slot_ff;
      wr_idx  = slot_ff;
      wr_data = rd_ff;
      unique case (cmd.op)
         OP_READ: rd_en = 1'b1;
         OP_RD_UP: begin
            rd_en  = 1'b1;
            rd_idx = sh_ff - CW'(1);
         end
         OP_RD_DN: begin
            rd_en  = 1'b1;
            rd_idx = slot_ff + CW'(1);
         end
         OP_WR_UP: begin
            wr_en  = 1'b1;
            wr_idx = sh_ff;
         end
         OP_WR_DN: wr_en = 1'b1;
         OP_INSERT: begin
            wr_en   = 1'b1;
            wr_data = '{key: req_ff.key, payload: req_ff.payload};
         end
         default: ;
      endcase
      rd_addr = AW'(blk_ix) * AW'(SLOTS_PER_BLOCK) + AW'(rd_idx[SW-1:0]);
      wr_addr = AW'(blk_ix) * AW'(SLOTS_PER_BLOCK) + AW'(wr_idx[SW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_OPEN:     counts[blk_ix] <= '0;
         OP_INSERT:   counts[blk_ix] <= cnt_cur + CW'(1);
         OP_REM_DONE: counts[blk_ix] <= cnt_cur - CW'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= '0;
         blk_ff   <= '0;
         slot_ff  <= '0;
         sh_ff    <= '0;
      end else if (cmd.clear) begin
         alloc_ff <= '0;
      end else begin
         unique case (cmd.op)
            OP_LOAD: begin
               blk_ff  <= '0;
               slot_ff <= '0;
            end
            OP_OPEN: begin
               alloc_ff <= blk_ff + BW'(1);
               slot_ff  <= '0;
            end
            OP_NEXT_BLK: begin
               blk_ff  <= blk_ff + BW'(1);
               slot_ff <= '0;
            end
            OP_NEXT_SLOT: slot_ff <= slot_ff + CW'(1);
            OP_SH_INIT:   sh_ff   <= cnt_cur;
            OP_WR_UP:     sh_ff   <= sh_ff - CW'(1);
            OP_WR_DN:     slot_ff <= slot_ff + CW'(1);
            default: ;
         endcase
      end
   end

   // Payload registers: request latch and result.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         req_ff <= req_data;
      end
      if (cmd.clear) begin
         rsp_ff <= '{status: ST_OK, found_payload: '0, block_index: '0, slot_index: '0};
      end else begin
         unique case (cmd.op)
            OP_INSERT: rsp_ff <= '{status: ST_OK, found_payload: '0,
                                   block_index: 4'(blk_ff), slot_index: 6'(slot_ff)};
            OP_HIT: rsp_ff <= '{status: ST_OK,
                                found_payload: stat.is_search ? rd_ff.payload : 32'd0,
                                block_index: 4'(blk_ff), slot_index: 6'(slot_ff)};
            OP_MISS: rsp_ff <= '{status: ST_NOT_FOUND, found_payload: '0,
                                 block_index: '0, slot_index: '0};
            OP_FULL: rsp_ff <= '{status: ST_FULL, found_payload: '0,
                                 block_index: '0, slot_index: '0};
            default: ;
         endcase
      end
   end

   always_comb begin
      stat.is_insert   = (req_ff.req_type == REQ_INSERT);
      stat.is_search   = (req_ff.req_type == REQ_SEARCH);
      stat.is_clear    = (req_ff.req_type == REQ_CLEAR);
      stat.alloc_zero  = (alloc_ff == '0);
      stat.alloc_full  = (alloc_ff == BW'(MAX_BLOCKS));
      stat.blk_end     = (blk_ff == alloc_ff);
      stat.blk_last    = ((blk_ff + BW'(1)) == alloc_ff);
      stat.cnt_full    = (cnt_cur == CW'(SLOTS_PER_BLOCK));
      stat.slot_at_cnt = (slot_ff == cnt_cur);
      stat.slot_last   = ((slot_ff + CW'(1)) == cnt_cur);
      stat.sh_at_slot  = (sh_ff == slot_ff);
      stat.key_lt      = (rd_ff.key < req_ff.key);
      stat.key_eq      = (rd_ff.key == req_ff.key);
   end

   assign rsp_data = rsp_ff;

endmodule

/* design/ssbs_ctrl.sv */
// Controller: sequences block scans, slot compares and entry moves.
module ssbs_ctrl
   import ssbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_FIND,
      S_INS_OPEN,
      S_INS_POS,
      S_INS_CMP,
      S_INS_SHIFT,
      S_INS_WR,
      S_SCAN_BLK,
      S_SCAN_SLOT,
      S_SCAN_CMP,
      S_REM_SHIFT,
      S_REM_WR,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_IDLE;
      cmd.clear = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (stat.is_clear) begin
               cmd.clear = 1'b1;
               state_in  = S_RESP;
            end else if (stat.is_insert) begin
               state_in = S_INS_FIND;
            end else begin
               state_in = S_SCAN_BLK;
            end
         end
         S_INS_FIND: begin
            priority if (stat.alloc_zero) begin
               cmd.op   = OP_OPEN;
               state_in = S_INS_POS;
            end else if (!stat.cnt_full) begin
               state_in = S_INS_POS;
            end else if (!stat.blk_last) begin
               cmd.op = OP_NEXT_BLK;
            end else if (stat.alloc_full) begin
               cmd.op   = OP_FULL;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_NEXT_BLK;
               state_in = S_INS_OPEN;
            end
         end
         S_INS_OPEN: begin
            cmd.op   = OP_OPEN;
            state_in = S_INS_POS;
         end
         S_INS_POS: begin
            if (stat.slot_at_cnt) begin
               cmd.op   = OP_SH_INIT;
               state_in = S_INS_SHIFT;
            end else begin
               cmd.op   = OP_READ;
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (stat.key_lt) begin
               cmd.op   = OP_NEXT_SLOT;
               state_in = S_INS_POS;
            end else begin
               cmd.op   = OP_SH_INIT;
               state_in = S_INS_SHIFT;
            end
         end
         S_INS_SHIFT: begin
            if (stat.sh_at_slot) begin
               cmd.op   = OP_INSERT;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_RD_UP;
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.op   = OP_WR_UP;
            state_in = S_INS_SHIFT;
         end
         S_SCAN_BLK: begin
            if (stat.blk_end) begin
               cmd.op   = OP_MISS;
               state_in = S_RESP;
            end else begin
               state_in = S_SCAN_SLOT;
            end
         end
         S_SCAN_SLOT: begin
            if (stat.slot_at_cnt) begin
               cmd.op   = OP_NEXT_BLK;
               state_in = S_SCAN_BLK;
            end else begin
               cmd.op   = OP_READ;
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (stat.key_eq) begin
               cmd.op   = OP_HIT;
               state_in = stat.is_search ? S_RESP : S_REM_SHIFT;
            end else begin
               cmd.op   = OP_NEXT_SLOT;
               state_in = S_SCAN_SLOT;
            end
         end
         S_REM_SHIFT: begin
            if (stat.slot_last) begin
               cmd.op   = OP_REM_DONE;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_RD_DN;
               state_in = S_REM_WR;
            end
         end
         S_REM_WR: begin
            cmd.op   = OP_WR_DN;
            state_in = S_REM_SHIFT;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

/* design/sequence_set_block_store.sv */
// Sequencing: each block visited, slot compared and entry moved adds to the time from
// acceptance to result valid, plus output wait; each compare reads the entry into a
// register, then tests it, and each move reads the entry, then writes it.
// Throughput: one item at a time; the next item can be taken in the cycle after the result is accepted.
// Reset: synchronous, clears the sequencer and empties the store; no clearing pass.
module sequence_set_block_store
   import ssbs_pkg::*;
#(
   parameter int SLOTS_PER_BLOCK = 64,
   parameter int MAX_BLOCKS      = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   ssbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssbs_dp #(
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
      .MAX_BLOCKS      (MAX_BLOCKS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

/* test/ssbs_checker.sv */
// Checker for the blocked sorted store: watches both channels, predicts results and compares.
module ssbs_checker
   import ssbs_pkg::*;
#(
   parameter int SLOTS_PER_BLOCK = 64,
   parameter int MAX_BLOCKS      = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_data,
   output int           fail_count,
   output int           pending_count
);

   localparam logic [31:0] EMPTY_KEY = 32'hFFFF_FFFF;

   logic [30:0] keys[MAX_BLOCKS * SLOTS_PER_BLOCK];
   logic [31:0] pays[MAX_BLOCKS * SLOTS_PER_BLOCK];
   int          counts[MAX_BLOCKS];
   logic [31:0] min_keys[MAX_BLOCKS];
   logic [31:0] max_keys[MAX_BLOCKS];
   int          used_blocks;
   rsp_item_type expected_rsps[$];

   function automatic rsp_item_type make_rsp(logic [1:0] st, logic [31:0] pay, int b, int s);
      rsp_item_type r;
      r.status = st;
      r.found_payload = pay;
      r.block_index = 4'(b);
      r.slot_index = 6'(s);
      return r;
   endfunction

   function automatic void fix_range(int b);
      if (counts[b] > 0) begin
         min_keys[b] = {1'b0, keys[b * SLOTS_PER_BLOCK]};
         max_keys[b] = {1'b0, keys[b * SLOTS_PER_BLOCK + counts[b] - 1]};
      end else begin
         min_keys[b] = EMPTY_KEY;
         max_keys[b] = EMPTY_KEY;
      end
   endfunction

   function automatic void open_blk(int b);
      counts[b] = 0;
      min_keys[b] = EMPTY_KEY;
      max_keys[b] = EMPTY_KEY;
      used_blocks = b + 1;
   endfunction

   function automatic int put_entry(int b, logic [30:0] k, logic [31:0] p);
      int base;
      int pos;
      base = b * SLOTS_PER_BLOCK;
      pos = 0;
      while (pos < counts[b] && keys[base + pos] < k) pos++;
      for (int i = counts[b]; i > pos; i--) begin
         keys[base + i] = keys[base + i - 1];
         pays[base + i] = pays[base + i - 1];
      end
      keys[base + pos] = k;
      pays[base + pos] = p;
      counts[b]++;
      fix_range(b);
      return pos;
   endfunction

   function automatic rsp_item_type store_access(req_item_type q);
      int base;
      case (q.req_type)
         REQ_INSERT: begin
            if (used_blocks == 0) open_blk(0);
            for (int b = 0; b < used_blocks; b++)
               if (counts[b] < SLOTS_PER_BLOCK)
                  return make_rsp(ST_OK, 0, b, put_entry(b, q.key, q.payload));
            if (used_blocks < MAX_BLOCKS) begin
               base = used_blocks;
               open_blk(base);
               return make_rsp(ST_OK, 0, base, put_entry(base, q.key, q.payload));
            end
            return make_rsp(ST_FULL, 0, 0, 0);
         end
         REQ_REMOVE: begin
            for (int b = 0; b < used_blocks; b++) begin
               base = b * SLOTS_PER_BLOCK;
               for (int i = 0; i < counts[b]; i++)
                  if (keys[base + i] == q.key) begin
                     for (int j = i; j + 1 < counts[b]; j++) begin
                        keys[base + j] = keys[base + j + 1];
                        pays[base + j] = pays[base + j + 1];
                     end
                     counts[b]--;
                     fix_range(b);
                     return make_rsp(ST_OK, 0, b, i);
                  end
            end
            return make_rsp(ST_NOT_FOUND, 0, 0, 0);
         end
         REQ_SEARCH: begin
            for (int b = 0; b < used_blocks; b++) begin
               if (min_keys[b] != EMPTY_KEY && {1'b0, q.key} < min_keys[b]) continue;
               if (max_keys[b] != EMPTY_KEY && {1'b0, q.key} > max_keys[b]) continue;
               base = b * SLOTS_PER_BLOCK;
               for (int i = 0; i < counts[b]; i++)
                  if (keys[base + i] == q.key)
                     return make_rsp(ST_OK, pays[base + i], b, i);
            end
            return make_rsp(ST_NOT_FOUND, 0, 0, 0);
         end
         default: begin
            used_blocks = 0;
            return make_rsp(ST_OK, 0, 0, 0);
         end
      endcase
   endfunction

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type predicted;
      if (reset) begin
         used_blocks = 0;
         expected_rsps.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = store_access(req_data);
            expected_rsps = {expected_rsps, predicted};
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected item on result channel: %p", rsp_data);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.found_payload !== want.found_payload) begin
                  $error("found_payload: expected %h, got %h",
                         want.found_payload, rsp_data.found_payload);
                  fail_count++;
               end
               if (rsp_data.block_index !== want.block_index) begin
                  $error("block_index: expected %0d, got %0d",
                         want.block_index, rsp_data.block_index);
                  fail_count++;
               end
               if (rsp_data.slot_index !== want.slot_index) begin
                  $error("slot_index: expected %0d, got %0d",
                         want.slot_index, rsp_data.slot_index);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

/* test/tb_sequence_set_block_store.sv */
// Testbench top for the blocked sorted store: stimulus, receiver stalls and verdict.
module tb_sequence_set_block_store;
   import ssbs_pkg::*;

   localparam int SLOTS = 64;
   localparam int BLOCKS = 16;
   localparam int STALL_LIMIT = 20000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;
   int           fail_count;
   int           pending_count;
   int           idle_cycles;
   bit           stim_done;
   bit           long_hold;
   logic [30:0]  used_keys[$];

   sequence_set_block_store #(.SLOTS_PER_BLOCK(SLOTS), .MAX_BLOCKS(BLOCKS)) dut (.*);

   ssbs_checker #(.SLOTS_PER_BLOCK(SLOTS), .MAX_BLOCKS(BLOCKS)) checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_item(logic [1:0] op, logic [30:0] k, logic [31:0] p);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= '{req_type: op, key: k, payload: p};
      req_valid <= 1'b1;
      // ready follows the state only, so it is settled at the falling edge
      while (!req_ready) @(negedge clock);
      @(negedge clock);
      if (op == REQ_INSERT) used_keys = {used_keys, k};
   endtask

   // pick mostly keys that were inserted before, so removes and searches tend to hit
   function automatic logic [30:0] pick_key();
      if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
         return used_keys[$urandom_range(0, used_keys.size() - 1)];
      case ($urandom_range(0, 3))
         0: return 31'($urandom_range(0, 40));
         1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
         default: return 31'($urandom);
      endcase
   endfunction

   initial begin
      logic [1:0] op;
      req_valid = 1'b0;
      req_data = '0;
      reset = 1'b1;
      stim_done = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: empty store, extremes, duplicates, empty block, search skip
      send_item(REQ_SEARCH, 31'd5, 32'd0);
      send_item(REQ_REMOVE, 31'd5, 32'd0);
      send_item(REQ_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(REQ_INSERT, 31'd0, 32'h0);
      send_item(REQ_INSERT, 31'd100, 32'hAAAA_5555);
      send_item(REQ_INSERT, 31'd100, 32'h5555_AAAA);
      send_item(REQ_SEARCH, 31'd100, 32'd0);
      send_item(REQ_SEARCH, 31'h7FFF_FFFF, 32'd0);
      send_item(REQ_SEARCH, 31'd50, 32'd0);
      send_item(REQ_REMOVE, 31'd100, 32'd0);
      send_item(REQ_SEARCH, 31'd100, 32'd0);
      send_item(REQ_CLEAR, 31'd0, 32'd0);
      send_item(REQ_SEARCH, 31'd0, 32'd0);
      used_keys.delete();
      // fill block 0 and spill into block 1
      for (int i = 0; i < SLOTS + 8; i++)
         send_item(REQ_INSERT, 31'($urandom_range(0, 2000)), $urandom);
      send_item(REQ_SEARCH, used_keys[0], 32'd0);
      // empty block 0 so later blocks keep ranges and block 0 reads empty
      for (int i = 0; i < SLOTS; i++) send_item(REQ_REMOVE, used_keys[i], 32'd0);
      send_item(REQ_SEARCH, used_keys[SLOTS + 1], 32'd0);
      send_item(REQ_INSERT, 31'd2500, 32'h1234_5678);
      send_item(REQ_SEARCH, 31'd2500, 32'd0);
      send_item(REQ_CLEAR, 31'd0, 32'd0);
      used_keys.delete();
      for (int n = 0; n < 450; n++) begin
         case ($urandom_range(0, 19))
            0: op = REQ_CLEAR;
            1, 2, 3, 4, 5, 6, 7, 8: op = REQ_INSERT;
            9, 10, 11, 12: op = REQ_REMOVE;
            default: op = REQ_SEARCH;
         endcase
         send_item(op, pick_key(), $urandom);
         if (op == REQ_CLEAR) used_keys.delete();
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver: random stalls, plus one long hold-off to back up the input
   initial begin
      rsp_ready = 1'b0;
      long_hold = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (40) @(negedge clock);
      long_hold = 1'b1;
      repeat (3000) @(negedge clock);
      long_hold = 1'b0;
      forever begin
         int gap;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         // valid follows the state only, so it is settled at the falling edge
         while (!rsp_valid) @(negedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || long_hold)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      fork
         begin
            wait (stim_done && pending_count == 0);
            repeat (300) @(posedge clock);
         end
         wait (idle_cycles >= STALL_LIMIT);
      join_any
      if (idle_cycles < STALL_LIMIT && fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* sequence_set_block_store.f */
design/ssbs_pkg.sv
design/ssbs_dp.sv
design/ssbs_ctrl.sv
design/sequence_set_block_store.sv
test/ssbs_checker.sv
test/tb_sequence_set_block_store.sv
